[rtl/core/sqmr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the shell quote marker rewriter.
// Used by sqmr_scan, sqmr_emit_buf and shell_quote_marker_rewriter.
package sqmr_pkg;

  // Scan modes (codes 6 and 7 behave as normal scanning)
  localparam logic [2:0] MODE_NORMAL   = 3'd0;
  localparam logic [2:0] MODE_DOLLAR   = 3'd1;
  localparam logic [2:0] MODE_BSLASH   = 3'd2;
  localparam logic [2:0] MODE_PLAIN    = 3'd3;
  localparam logic [2:0] MODE_DQUOTE   = 3'd4;
  localparam logic [2:0] MODE_AFTER_DQ = 3'd5;

  localparam logic [7:0] MARK_AFTER  = 8'h01;
  localparam logic [7:0] MARK_SINGLE = 8'h02;
  localparam logic [7:0] MARK_DOUBLE = 8'h03;
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_SQUOTE   = 8'h27;
  localparam logic [7:0] CH_DQUOTE   = 8'h22;

  // Result slots for one input byte: optional prefix, optional main byte,
  // optional terminator, always in that order.
  typedef struct packed {
    logic       pre_v;
    logic [7:0] pre_b;
    logic       main_v;
    logic [7:0] main_b;
    logic       nul_v;
    logic [2:0] mode_next;
    logic       dq_next;
  } scan_res_t;

  // One buffered result
  typedef struct packed {
    logic [7:0] data;
    logic       string_end;
    logic       run_last;
  } res_t;

endpackage

[rtl/core/sqmr_scan.sv]
`timescale 1ns / 1ps
// Rewrite logic for one byte: results and next scan state.
// Depends on sqmr_pkg.
module sqmr_scan (
  input  logic [2:0]          mode,
  input  logic                dq,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output sqmr_pkg::scan_res_t res
);

  logic       is_dollar;
  logic       is_bslash;
  logic       is_squote;
  logic       is_dquote;
  logic       is_quote;
  logic       is_open_q;
  // scan_normal outcome
  logic       sn_v;
  logic [7:0] sn_b;
  logic [2:0] sn_mode;
  logic       sn_dq;

  assign is_dollar = (in_byte == sqmr_pkg::CH_DOLLAR);
  assign is_bslash = (in_byte == sqmr_pkg::CH_BSLASH);
  assign is_squote = (in_byte == sqmr_pkg::CH_SQUOTE);
  assign is_dquote = (in_byte == sqmr_pkg::CH_DQUOTE);
  assign is_quote  = is_squote | is_dquote;
  assign is_open_q = dq ? is_dquote : is_squote;

  always_comb begin
    sn_v    = 1'b1;
    sn_b    = in_byte;
    sn_mode = sqmr_pkg::MODE_NORMAL;
    sn_dq   = dq;
    if (is_dollar || is_bslash) begin
      sn_v    = in_last;
      sn_mode = is_dollar ? sqmr_pkg::MODE_DOLLAR : sqmr_pkg::MODE_BSLASH;
    end else if (is_quote) begin
      sn_b    = is_dquote ? sqmr_pkg::MARK_DOUBLE : sqmr_pkg::MARK_SINGLE;
      sn_mode = sqmr_pkg::MODE_PLAIN;
      sn_dq   = is_dquote;
    end
  end

  always_comb begin
    res.pre_v     = 1'b0;
    res.pre_b     = in_byte;
    res.main_v    = sn_v;
    res.main_b    = sn_b;
    res.mode_next = sn_mode;
    res.dq_next   = sn_dq;
    case (mode)
      sqmr_pkg::MODE_DOLLAR: begin
        if (is_quote) begin
          res.main_v    = 1'b0;
          res.mode_next = sqmr_pkg::MODE_DQUOTE;
          res.dq_next   = is_dquote;
        end else begin
          res.pre_v = 1'b1;
          res.pre_b = sqmr_pkg::CH_DOLLAR;
        end
      end
      sqmr_pkg::MODE_BSLASH: begin
        res.pre_v     = is_dollar;
        res.pre_b     = sqmr_pkg::CH_BSLASH;
        res.main_v    = 1'b1;
        res.main_b    = in_byte;
        res.mode_next = sqmr_pkg::MODE_NORMAL;
        res.dq_next   = dq;
      end
      sqmr_pkg::MODE_PLAIN: begin
        res.main_v    = 1'b1;
        res.main_b    = is_open_q
                        ? (dq ? sqmr_pkg::MARK_DOUBLE : sqmr_pkg::MARK_SINGLE)
                        : in_byte;
        res.mode_next = is_open_q ? sqmr_pkg::MODE_NORMAL : sqmr_pkg::MODE_PLAIN;
        res.dq_next   = dq;
      end
      sqmr_pkg::MODE_DQUOTE: begin
        res.main_v    = ~is_open_q;
        res.main_b    = in_byte;
        res.mode_next = is_open_q ? sqmr_pkg::MODE_AFTER_DQ : sqmr_pkg::MODE_DQUOTE;
        res.dq_next   = dq;
      end
      sqmr_pkg::MODE_AFTER_DQ: begin
        res.pre_v = 1'b1;
        res.pre_b = sqmr_pkg::MARK_AFTER;
      end
      default: begin
      end
    endcase
    res.nul_v = in_last;
    if (in_last) begin
      res.mode_next = sqmr_pkg::MODE_NORMAL;
      res.dq_next   = 1'b0;
    end
  end

endmodule

[rtl/core/sqmr_emit_buf.sv]
`timescale 1ns / 1ps
// Three-entry result buffer: loads the packed results of one byte and
// shifts them out one per transfer. Depends on sqmr_pkg.
module sqmr_emit_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  sqmr_pkg::scan_res_t res,
  input  logic                pop,
  output logic                can_load,
  output logic                head_valid,
  output sqmr_pkg::res_t      head
);

  logic [1:0]     cnt;
  logic [1:0]     cnt_next;
  sqmr_pkg::res_t ent [3];
  sqmr_pkg::res_t ent_next [3];
  logic [1:0]     n_new;
  sqmr_pkg::res_t s_pre;
  sqmr_pkg::res_t s_main;
  sqmr_pkg::res_t s_nul;

  assign n_new = {1'b0, res.pre_v} + {1'b0, res.main_v} + {1'b0, res.nul_v};

  // run_last marks whichever slot is the last one present
  assign s_pre  = '{data: res.pre_b, string_end: 1'b0,
                    run_last: ~res.main_v & ~res.nul_v};
  assign s_main = '{data: res.main_b, string_end: 1'b0, run_last: ~res.nul_v};
  assign s_nul  = '{data: sqmr_pkg::CH_NUL, string_end: 1'b1, run_last: 1'b1};

  assign head_valid = (cnt != 2'd0);
  assign head       = ent[0];
  assign can_load   = (cnt == 2'd0) || ((cnt == 2'd1) && pop);

  always_comb begin
    cnt_next    = cnt;
    ent_next[0] = ent[0];
    ent_next[1] = ent[1];
    ent_next[2] = ent[2];
    if (load) begin
      cnt_next    = n_new;
      ent_next[0] = res.pre_v ? s_pre : (res.main_v ? s_main : s_nul);
      ent_next[1] = (res.pre_v && res.main_v) ? s_main : s_nul;
      ent_next[2] = s_nul;
    end else if (pop) begin
      cnt_next    = cnt - 2'd1;
      ent_next[0] = ent[1];
      ent_next[1] = ent[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
    ent[0] <= ent_next[0];
    ent[1] <= ent_next[1];
    ent[2] <= ent_next[2];
  end

endmodule

[rtl/core/shell_quote_marker_rewriter.sv]
`timescale 1ns / 1ps
// Shell quote marker rewriter, top level. Uses sqmr_pkg, sqmr_scan and
// sqmr_emit_buf.
//
// Takes a command string one byte per transfer (in_last on its final byte)
// and emits the marked form one byte per transfer: single- and double-quoted
// sections are wrapped in 0x02 / 0x03, $-quoted sections lose their quotes
// and get 0x01 before the following byte, backslashes outside quotes are
// dropped except before $, and every string ends in a NUL result with
// string_end set. run_last flags the final result caused by an input byte;
// a byte that yields nothing (a pending $ or backslash, a $-quote opener or
// closer) produces no result. A byte is registered on input, then rewritten
// into a three-entry result buffer once the buffer can load it. An input
// byte holds the result buffer until its results (zero to three) have left;
// the buffer loads the next byte in the same cycle that its last entry
// leaves, so a stream of one-result bytes runs at one byte per cycle while
// the receiver does not stall.
module shell_quote_marker_rewriter (
  input  logic       clk,
  input  logic       rst,
  // input byte stream
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  // rewritten byte stream
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       string_end,
  output logic       run_last
);

  // Input register
  logic       in_full;
  logic [7:0] in_data;
  logic       in_end;

  // Scan state: mode and whether the open quote is a double quote
  logic [2:0] mode;
  logic       dq;

  sqmr_pkg::scan_res_t scan_res;
  sqmr_pkg::res_t      head;
  logic                head_valid;
  logic                can_load;
  logic                pop;
  logic                take;
  logic                in_xfer;

  assign pop      = head_valid & ~out_stall;
  assign take     = in_full & can_load;      // held byte moves into the buffer
  assign in_stall = in_full & ~can_load;
  assign in_xfer  = in_valid & ~in_stall;

  assign out_valid  = head_valid;
  assign out_byte   = head.data;
  assign string_end = head.string_end;
  assign run_last   = head.run_last;

  sqmr_scan u_scan (
    .mode    (mode),
    .dq      (dq),
    .in_byte (in_data),
    .in_last (in_end),
    .res     (scan_res)
  );

  sqmr_emit_buf u_buf (
    .clk        (clk),
    .rst        (rst),
    .load       (take),
    .res        (scan_res),
    .pop        (pop),
    .can_load   (can_load),
    .head_valid (head_valid),
    .head       (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      mode    <= sqmr_pkg::MODE_NORMAL;
      dq      <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_full <= 1'b1;
      end else if (take) begin
        in_full <= 1'b0;
      end
      // state advances once per byte, when it is rewritten
      if (take) begin
        mode <= scan_res.mode_next;
        dq   <= scan_res.dq_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_data <= in_byte;
      in_end  <= in_last;
    end
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for shell_quote_marker_rewriter.
// Needs sqmr_pkg and the rewriter RTL. Predicts the marked byte stream in-bench
// and checks every output transfer against it, field by field.
module testbench;

  // One byte of a command string, as offered on the input channel
  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } cmd_byte_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       string_end;
  logic       run_last;

  shell_quote_marker_rewriter i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .string_end (string_end),
    .run_last   (run_last)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stimulus bytes not yet offered, and marked results not yet seen
  cmd_byte_t      byte_q[$];
  sqmr_pkg::res_t marked_q[$];
  logic [7:0]     step_bytes[$];    // results of the byte being predicted

  int bytes_queued = 0;
  int bytes_taken  = 0;
  int err_cnt      = 0;

  // Idle/stall odds in percent, changed per phase
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic recv_hold      = 1'b0;  // long receiver hold-off in progress
  logic hold_armed     = 1'b0;

  // set at the edge where the offered byte was taken, cleared by the driver
  logic in_moved = 1'b0;

  // Predictor state: scan mode and which quote opened the current section
  logic [2:0] rw_mode = sqmr_pkg::MODE_NORMAL;
  logic       rw_dq   = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] quote_byte();
    return rw_dq ? sqmr_pkg::CH_DQUOTE : sqmr_pkg::CH_SQUOTE;
  endfunction

  function automatic logic [7:0] section_mark();
    return rw_dq ? sqmr_pkg::MARK_DOUBLE : sqmr_pkg::MARK_SINGLE;
  endfunction

  // A byte seen in normal scanning. A $ or backslash waits for the next byte,
  // unless the string ends here, in which case it goes out as is.
  task automatic scan_plain(input logic [7:0] c, input logic lst);
    if (c == sqmr_pkg::CH_DOLLAR || c == sqmr_pkg::CH_BSLASH) begin
      if (lst)
        step_bytes.push_back(c);
      else
        rw_mode = (c == sqmr_pkg::CH_DOLLAR) ? sqmr_pkg::MODE_DOLLAR
                                             : sqmr_pkg::MODE_BSLASH;
    end else if (c == sqmr_pkg::CH_SQUOTE || c == sqmr_pkg::CH_DQUOTE) begin
      rw_dq = (c == sqmr_pkg::CH_DQUOTE);
      step_bytes.push_back(section_mark());
      rw_mode = sqmr_pkg::MODE_PLAIN;
    end else begin
      step_bytes.push_back(c);
    end
  endtask

  // Works out the results of one accepted byte and queues them in order.
  task automatic rewrite_byte(input logic [7:0] c, input logic lst);
    logic [2:0]     mode;
    sqmr_pkg::res_t r;
    int             n;
    mode = rw_mode;
    rw_mode = sqmr_pkg::MODE_NORMAL;
    step_bytes.delete();
    case (mode)
      sqmr_pkg::MODE_DOLLAR: begin
        if (c == sqmr_pkg::CH_SQUOTE || c == sqmr_pkg::CH_DQUOTE) begin
          // $-quote opens: quotes are dropped
          rw_dq = (c == sqmr_pkg::CH_DQUOTE);
          rw_mode = sqmr_pkg::MODE_DQUOTE;
        end else begin
          step_bytes.push_back(sqmr_pkg::CH_DOLLAR);
          scan_plain(c, lst);
        end
      end
      sqmr_pkg::MODE_BSLASH: begin
        // backslash survives only in front of $
        if (c == sqmr_pkg::CH_DOLLAR)
          step_bytes.push_back(sqmr_pkg::CH_BSLASH);
        step_bytes.push_back(c);
      end
      sqmr_pkg::MODE_PLAIN: begin
        if (c == quote_byte()) begin
          step_bytes.push_back(section_mark());
        end else begin
          step_bytes.push_back(c);
          rw_mode = sqmr_pkg::MODE_PLAIN;
        end
      end
      sqmr_pkg::MODE_DQUOTE: begin
        if (c == quote_byte()) begin
          rw_mode = sqmr_pkg::MODE_AFTER_DQ;
        end else begin
          step_bytes.push_back(c);
          rw_mode = sqmr_pkg::MODE_DQUOTE;
        end
      end
      sqmr_pkg::MODE_AFTER_DQ: begin
        step_bytes.push_back(sqmr_pkg::MARK_AFTER);
        scan_plain(c, lst);
      end
      default: scan_plain(c, lst);
    endcase
    if (lst) begin
      step_bytes.push_back(sqmr_pkg::CH_NUL);
      rw_mode = sqmr_pkg::MODE_NORMAL;
      rw_dq = 1'b0;
    end
    n = step_bytes.size();
    for (int k = 0; k < n; k++) begin
      r.data       = step_bytes[k];
      r.string_end = lst && (k == n - 1);
      r.run_last   = (k == n - 1);
      marked_q.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (err_cnt < 40)
      $display("%0t ns: %s", $time, msg);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: changes at the falling edge. A byte stays on the port until
  // a rising edge took it; only then may the next one (or an idle) follow.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_in
    cmd_byte_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_moved) begin
      in_moved = 1'b0;
      if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = byte_q.pop_front();
        in_byte  <= nxt.b;
        in_last  <= nxt.last;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random odds, or forced high during the long hold-off
  always @(negedge clk) begin
    if (rst)
      out_stall <= 1'b0;
    else
      out_stall <= recv_hold || ($urandom_range(99) < recv_stall_pct);
  end

  // Long hold-off, counted here in cycles. The sender keeps offering, so the
  // block fills its buffer and has to stall the input side.
  initial begin : long_hold
    wait (hold_armed);
    recv_hold = 1'b1;
    repeat (200) @(negedge clk);
    recv_hold = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: at the rising edge, take note of an input transfer (feeds the
  // predictor) and check an output transfer against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    sqmr_pkg::res_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        rewrite_byte(in_byte, in_last);
        in_moved = 1'b1;
        bytes_taken++;
      end
      if (out_valid && !out_stall) begin
        if (marked_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte %02h", out_byte));
        end else begin
          want = marked_q.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.data));
          if (string_end !== want.string_end)
            report_mismatch($sformatf("string_end %b, want %b on byte %02h",
                                      string_end, want.string_end, want.data));
          if (run_last !== want.run_last)
            report_mismatch($sformatf("run_last %b, want %b on byte %02h",
                                      run_last, want.run_last, want.data));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Queues one string; in_last goes on its final byte
  task automatic push_bytes(input logic [7:0] s[$]);
    cmd_byte_t e;
    foreach (s[i]) begin
      e.b    = s[i];
      e.last = (i == s.size() - 1);
      byte_q.push_back(e);
      bytes_queued++;
    end
  endtask

  // Mostly syntax bytes, else anything but NUL
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return sqmr_pkg::CH_DOLLAR;
      1: return sqmr_pkg::CH_BSLASH;
      2: return sqmr_pkg::CH_SQUOTE;
      3: return sqmr_pkg::CH_DQUOTE;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // A random command string built from tokens: words, quoted and $-quoted
  // sections (now and then left open), escapes, lone $ and raw noise bytes.
  task automatic queue_random_string();
    logic [7:0] s[$];
    logic [7:0] q;
    int         tok;
    repeat ($urandom_range(1, 4)) begin
      tok = $urandom_range(9);
      case (tok)
        0: repeat ($urandom_range(1, 3)) s.push_back(8'($urandom_range(8'h61, 8'h7a)));
        1, 2, 3, 4: begin
          if (tok >= 3)
            s.push_back(sqmr_pkg::CH_DOLLAR);
          q = tok[0] ? sqmr_pkg::CH_SQUOTE : sqmr_pkg::CH_DQUOTE;
          s.push_back(q);
          repeat ($urandom_range(0, 3)) s.push_back(pick_byte());
          if ($urandom_range(9) != 0)
            s.push_back(q);
        end
        5: begin
          s.push_back(sqmr_pkg::CH_BSLASH);
          s.push_back(pick_byte());
        end
        6: begin
          s.push_back(sqmr_pkg::CH_BSLASH);
          s.push_back(sqmr_pkg::CH_DOLLAR);
        end
        7: begin
          s.push_back(sqmr_pkg::CH_DOLLAR);
          s.push_back(pick_byte());
        end
        default: s.push_back(pick_byte());
      endcase
    end
    push_bytes(s);
  endtask

  // Wait until every queued byte went in and every result came out
  task automatic drain();
    while (bytes_taken != bytes_queued || marked_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_random_phase(input int send_pct, input int recv_pct);
    int start;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start = bytes_queued;
    while (bytes_queued - start < 72)
      queue_random_string();
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    logic [7:0] str[$];
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_byte   = 8'h00;
    in_last   = 1'b0;
    out_stall = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed strings, no idling on either side
    // byte 0x01 and largest byte
    str = '{sqmr_pkg::MARK_AFTER, 8'hFF};
    push_bytes(str);
    // single-quoted section
    str = '{sqmr_pkg::CH_SQUOTE, 8'h78, sqmr_pkg::CH_SQUOTE};
    push_bytes(str);
    // double quote never closed
    str = '{sqmr_pkg::CH_DQUOTE, 8'h79};
    push_bytes(str);
    // marker after $-quote
    str = '{sqmr_pkg::CH_DOLLAR, sqmr_pkg::CH_SQUOTE, 8'h7A, sqmr_pkg::CH_SQUOTE,
            8'h71};
    push_bytes(str);
    // $-quote closes at the end
    str = '{sqmr_pkg::CH_DOLLAR, sqmr_pkg::CH_DQUOTE, 8'h77, sqmr_pkg::CH_DQUOTE};
    push_bytes(str);
    // escaped quote, \$ kept
    str = '{sqmr_pkg::CH_BSLASH, sqmr_pkg::CH_SQUOTE, sqmr_pkg::CH_BSLASH,
            sqmr_pkg::CH_DOLLAR};
    push_bytes(str);
    // $ pending at the end
    str = '{8'h61, sqmr_pkg::CH_DOLLAR};
    push_bytes(str);
    // backslash pending at the end
    str = '{8'h80, sqmr_pkg::CH_BSLASH};
    push_bytes(str);
    // zero byte, open $-quote
    str = '{sqmr_pkg::CH_NUL, sqmr_pkg::CH_DOLLAR, sqmr_pkg::CH_SQUOTE};
    push_bytes(str);
    drain();

    // Random strings over the idling phases; the first one also carries
    // the long receiver hold-off while the sender runs flat out.
    hold_armed = 1'b1;
    run_random_phase(0, 0);
    run_random_phase(77, 0);
    run_random_phase(0, 77);
    run_random_phase(12, 12);

    // let any stray result show up before the verdict
    repeat (16) @(negedge clk);
    if (err_cnt == 0 && marked_q.size() == 0)
      $display("shell_quote_marker_rewriter: match");
    else
      $display("shell_quote_marker_rewriter: mismatch");
    $finish;
  end

  // Run limit, far above the slowest correct run
  initial begin : watchdog
    #200000;
    $display("shell_quote_marker_rewriter: mismatch");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/sqmr_pkg.sv
rtl/core/sqmr_scan.sv
rtl/core/sqmr_emit_buf.sv
rtl/core/shell_quote_marker_rewriter.sv
test/testbench.sv
